// ===== rtl/trf_pkg.sv =====
// Shared types, constants and codes for the temperature reading acceptance filter.
`timescale 1ns / 1ps

package trf_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = 17 + IDX_W;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL        = 1'd1;

    localparam logic [3:0]  RESOLUTION_RESET = 4'd12;
    localparam logic [31:0] TTL_RESET        = 32'd60000;

    localparam logic [3:0] RES_9  = 4'd9;
    localparam logic [3:0] RES_10 = 4'd10;
    localparam logic [3:0] RES_11 = 4'd11;

    localparam logic [7:0] EXPECT_9   = 8'h1F;
    localparam logic [7:0] EXPECT_10  = 8'h3F;
    localparam logic [7:0] EXPECT_11  = 8'h5F;
    localparam logic [7:0] EXPECT_12  = 8'h7F;
    localparam logic [7:0] MASK_9     = 8'hF8;
    localparam logic [7:0] MASK_10    = 8'hFC;
    localparam logic [7:0] MASK_11    = 8'hFE;
    localparam logic [7:0] MASK_12    = 8'hFF;

    localparam logic [3:0]         MAX_ATTEMPTS = 4'd10;
    localparam logic [CNT_W-1:0]   MIN_READINGS = CNT_W'(3);
    localparam logic signed [15:0] DISCARD_RAW  = 16'sd1360;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_DISCARDED = 3'd2;
    localparam logic [2:0] ST_CRC_RETRY = 3'd3;
    localparam logic [2:0] ST_GAVE_UP   = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;
    localparam logic [2:0] ST_QUERY     = 3'd6;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  temp_low_byte;
        logic [7:0]  temp_high_byte;
        logic [7:0]  config_byte;
        logic        crc_ok;
        logic [31:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] temperature;
        logic               temp_valid;
        logic [4:0]         reading_count;
    } out_beat_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic sum_step;
        logic compare;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_avg;
        logic sum_done;
    } dp_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SUM,
        S_CMP,
        S_EMIT
    } trf_state_t;

endpackage

// ===== rtl/temperature_reading_acceptance_filter.sv =====
// Top level of the temperature reading acceptance filter.
`timescale 1ns / 1ps

// Takes one beat at a time: a scratchpad read (func 0) or a query (func 1), and returns one
// result beat for each. A beat whose outcome is settled without the average check passes
// from evaluation straight to the emit state; when the average check runs, the history ring
// is walked through its single read port one entry per cycle, over every held reading (16 at
// most with a 16-entry ring), then compared before emit. The next beat is taken once the result
// has been placed in the output register, even while that result still waits downstream.
// Configuration writes take effect at once and are expected only while the block is idle.
module temperature_reading_acceptance_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [trf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  trf_pkg::in_beat_t              in_beat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output trf_pkg::out_beat_t             out_beat
);
    import trf_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    trf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    trf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== rtl/trf_ctrl.sv =====
// Controller state machine sequencing capture, evaluation, averaging and result hand-off.
`timescale 1ns / 1ps

module trf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  trf_pkg::dp_sts_t  sts,
    output trf_pkg::ctl_cmd_t cmd
);
    import trf_pkg::*;

    trf_state_t state_reg;
    trf_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.need_avg ? S_SUM : S_EMIT;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/trf_datapath.sv =====
// Datapath: configuration, filter state, history ring, averaging accumulator and result register.
`timescale 1ns / 1ps

module trf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  trf_pkg::in_beat_t                   in_beat,
    output trf_pkg::out_beat_t                  out_beat,
    input  trf_pkg::ctl_cmd_t                   cmd,
    output trf_pkg::dp_sts_t                    sts
);
    import trf_pkg::*;

    logic signed [15:0] ring_mem [HISTORY_DEPTH];

    logic [3:0]               resolution_reg;
    logic [31:0]              ttl_reg;
    in_beat_t                 in_reg;
    logic [IDX_W-1:0]         widx_reg, widx_next;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic signed [15:0]       cur_reg, cur_next;
    logic                     ok_reg, ok_next;
    logic [31:0]              last_reg, last_next;
    logic [3:0]               attempt_reg, attempt_next;
    logic [2:0]               status_reg, status_next;
    logic signed [15:0]       v_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic                     rd_pend_reg;
    logic signed [15:0]       rd_data_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  prod_reg;
    out_beat_t                out_reg;

    logic [7:0]               expect_byte;
    logic [7:0]               lsb_mask;
    logic signed [15:0]       v_calc;
    logic                     wr_en;
    logic                     need_avg;
    logic [CNT_W-1:0]         held_inc;
    logic signed [16:0]       diff;
    logic [31:0]              age;
    logic [IDX_W-1:0]         pos_dec;
    logic                     rd_en;
    logic signed [SUM_W-1:0]  v_ext;
    logic signed [SUM_W-1:0]  held_ext;
    logic signed [SUM_W:0]    delta;
    logic [SUM_W:0]           delta_abs;
    logic                     avg_close;

    always_comb
    begin
        case (resolution_reg)
            RES_9:
            begin
                expect_byte = EXPECT_9;
                lsb_mask    = MASK_9;
            end
            RES_10:
            begin
                expect_byte = EXPECT_10;
                lsb_mask    = MASK_10;
            end
            RES_11:
            begin
                expect_byte = EXPECT_11;
                lsb_mask    = MASK_11;
            end
            default:
            begin
                expect_byte = EXPECT_12;
                lsb_mask    = MASK_12;
            end
        endcase
    end

    assign v_calc   = $signed({in_reg.temp_high_byte, in_reg.temp_low_byte & lsb_mask});
    assign held_inc = (held_reg < CNT_W'(HISTORY_DEPTH)) ? held_reg + CNT_W'(1) : held_reg;
    assign diff     = {cur_reg[15], cur_reg} - {v_calc[15], v_calc};
    assign age      = in_reg.now_ms - last_reg;

    always_comb
    begin
        widx_next    = widx_reg;
        held_next    = held_reg;
        cur_next     = cur_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;
        attempt_next = attempt_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        need_avg     = 1'b0;
        if (in_reg.func == FUNC_QUERY)
        begin
            status_next = ST_QUERY;
            if ((held_reg != '0) && (age > ttl_reg))
            begin
                held_next = '0;
                ok_next   = 1'b0;
            end
        end
        else if (attempt_reg > MAX_ATTEMPTS)
        begin
            attempt_next = '0;
            status_next  = ST_GAVE_UP;
        end
        else if (!in_reg.crc_ok)
        begin
            attempt_next = attempt_reg + 4'd1;
            status_next  = ST_CRC_RETRY;
        end
        else
        begin
            attempt_next = '0;
            if (in_reg.config_byte != expect_byte)
            begin
                status_next = ST_MISMATCH;
            end
            else if (v_calc == DISCARD_RAW)
            begin
                status_next = ST_DISCARDED;
            end
            else
            begin
                wr_en     = 1'b1;
                widx_next = (widx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                    : widx_reg + IDX_W'(1);
                last_next = in_reg.now_ms;
                held_next = held_inc;
                if (held_inc == MIN_READINGS)
                begin
                    cur_next    = v_calc;
                    ok_next     = 1'b1;
                    status_next = ST_ACCEPTED;
                end
                else if ((held_inc < MIN_READINGS) || (ok_reg && (v_calc == cur_reg)))
                begin
                    status_next = ST_UNCHANGED;
                end
                else if (!ok_reg)
                begin
                    cur_next    = v_calc;
                    ok_next     = 1'b1;
                    status_next = ST_ACCEPTED;
                end
                else if ((diff >= 17'sd2) || (diff <= -17'sd2))
                begin
                    cur_next    = v_calc;
                    status_next = ST_ACCEPTED;
                end
                else
                begin
                    need_avg = 1'b1;
                end
            end
        end
    end

    assign pos_dec   = (pos_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : pos_reg - IDX_W'(1);
    assign rd_en     = cmd.sum_step && (rem_reg != '0);
    assign v_ext     = SUM_W'(v_reg);
    assign held_ext  = $signed(SUM_W'(held_reg));
    assign delta     = ((SUM_W + 1)'(acc_reg) - (SUM_W + 1)'(prod_reg)) <<< 1;
    assign delta_abs = (delta < 0) ? $unsigned(-delta) : $unsigned(delta);
    assign avg_close = (delta_abs < (SUM_W + 1)'(held_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.eval && wr_en)
        begin
            ring_mem[widx_reg] <= v_calc;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[pos_dec];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RESOLUTION_RESET;
            ttl_reg        <= TTL_RESET;
            widx_reg       <= '0;
            held_reg       <= '0;
            cur_reg        <= '0;
            ok_reg         <= 1'b0;
            last_reg       <= '0;
            attempt_reg    <= '0;
            rem_reg        <= '0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESOLUTION: resolution_reg <= cfg_data[3:0];
                    CFG_TTL:        ttl_reg        <= cfg_data[31:0];
                    default:        ;
                endcase
            end
            if (cmd.eval)
            begin
                widx_reg    <= widx_next;
                held_reg    <= held_next;
                cur_reg     <= cur_next;
                ok_reg      <= ok_next;
                last_reg    <= last_next;
                attempt_reg <= attempt_next;
                if (need_avg)
                begin
                    rem_reg     <= held_next;
                    rd_pend_reg <= 1'b0;
                end
            end
            if (cmd.sum_step)
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                begin
                    rem_reg <= rem_reg - CNT_W'(1);
                end
            end
            if (cmd.compare && avg_close)
            begin
                cur_reg <= v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_beat;
        end
        if (cmd.eval)
        begin
            status_reg <= status_next;
            v_reg      <= v_calc;
            pos_reg    <= widx_next;
            acc_reg    <= '0;
        end
        if (cmd.sum_step)
        begin
            prod_reg <= v_ext * held_ext;
            if (rd_en)
            begin
                pos_reg <= pos_dec;
            end
            if (rd_pend_reg)
            begin
                acc_reg <= acc_reg + SUM_W'(rd_data_reg);
            end
        end
        if (cmd.compare)
        begin
            status_reg <= avg_close ? ST_ACCEPTED : ST_UNCHANGED;
        end
        if (cmd.load_out)
        begin
            out_reg.status        <= status_reg;
            out_reg.temperature   <= ok_reg ? cur_reg : 16'sd0;
            out_reg.temp_valid    <= ok_reg;
            out_reg.reading_count <= 5'(held_reg);
        end
    end

    assign sts.need_avg = need_avg;
    assign sts.sum_done = (rem_reg == '0) && !rd_pend_reg;
    assign out_beat     = out_reg;

endmodule
